@@ sv/assert_macros.svh @@
// Assertion macros for the RTL top level, which checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define DTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define DTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/dtp_pkg.sv @@
// Types and constants shared by the framed decimal triple parser.
`default_nettype none

package dtp_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 4;

  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [1:0] LastField = 2'd2;
  localparam logic [1:0] PastLast  = 2'd3;

  typedef enum logic [2:0] {
    CLS_HASH,
    CLS_BANG,
    CLS_COMMA,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_BLANK,
    CLS_OTHER
  } byte_class_e;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } parse_phase_e;

  typedef struct packed {
    byte_class_e cls;
    logic [3:0]  digit;
  } cmd_t;

  typedef struct packed {
    logic signed [ValW-1:0] value_one;
    logic signed [ValW-1:0] value_two;
    logic signed [ValW-1:0] value_three;
    logic [1:0]             fields_seen;
  } result_t;

endpackage

`default_nettype wire

@@ sv/dtp_front.sv @@
// Front end: classifies received bytes and queues them for the parser.
`default_nettype none

module dtp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [7:0]    rx_byte_i,
  output logic               full_o,
  output logic               cmd_valid_o,
  output dtp_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_ready_i
);

  dtp_pkg::cmd_t cmd_in;
  dtp_pkg::cmd_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic          v0_q, v0_d, v1_q, v1_d;
  logic          push_fire, pop_fire;

  always_comb begin
    cmd_in.digit = rx_byte_i[3:0];
    priority if (rx_byte_i == dtp_pkg::CharHash) begin
      cmd_in.cls = dtp_pkg::CLS_HASH;
    end else if (rx_byte_i == dtp_pkg::CharBang) begin
      cmd_in.cls = dtp_pkg::CLS_BANG;
    end else if (rx_byte_i == dtp_pkg::CharComma) begin
      cmd_in.cls = dtp_pkg::CLS_COMMA;
    end else if (rx_byte_i == dtp_pkg::CharPlus) begin
      cmd_in.cls = dtp_pkg::CLS_PLUS;
    end else if (rx_byte_i == dtp_pkg::CharMinus) begin
      cmd_in.cls = dtp_pkg::CLS_MINUS;
    end else if (rx_byte_i >= dtp_pkg::CharZero && rx_byte_i <= dtp_pkg::CharNine) begin
      cmd_in.cls = dtp_pkg::CLS_DIGIT;
    end else if (rx_byte_i == dtp_pkg::CharSpace ||
                 (rx_byte_i >= dtp_pkg::CharTab && rx_byte_i <= dtp_pkg::CharCr)) begin
      cmd_in.cls = dtp_pkg::CLS_BLANK;
    end else begin
      cmd_in.cls = dtp_pkg::CLS_OTHER;
    end
  end

  assign full_o      = v1_q;
  assign cmd_valid_o = v0_q;
  assign cmd_o       = slot0_q;
  assign push_fire   = push_i & ~v1_q;
  assign pop_fire    = cmd_ready_i & v0_q;

  // Two-entry queue: slot0 is the head, slot1 takes a transaction behind it.
  always_comb begin
    v0_d    = v0_q;
    v1_d    = v1_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop_fire) begin
      if (v1_q) begin
        slot0_d = slot1_q;
        v1_d    = 1'b0;
      end else if (push_fire) begin
        slot0_d = cmd_in;
      end else begin
        v0_d = 1'b0;
      end
    end else if (push_fire) begin
      if (!v0_q) begin
        slot0_d = cmd_in;
        v0_d    = 1'b1;
      end else begin
        slot1_d = cmd_in;
        v1_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

@@ sv/dtp_back.sv @@
// Back end: frame and field parser with a two-entry result queue.
`default_nettype none

module dtp_back #(
  parameter int unsigned MAX_FIELD_CHARS = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  dtp_pkg::cmd_t      cmd_i,
  output logic               cmd_ready_o,
  output logic               res_valid_o,
  output dtp_pkg::result_t   res_o,
  input  wire logic          res_pop_i
);

  localparam logic [dtp_pkg::CountW-1:0] MaxCount = dtp_pkg::CountW'(MAX_FIELD_CHARS);
  localparam int unsigned ProdW = dtp_pkg::ValW + 4;
  localparam int unsigned SumW  = ProdW + 1;
  localparam logic signed [SumW-1:0] SatMax = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sd2147483648);

  logic                          in_frame_q, in_frame_d;
  logic [1:0]                    idx_q, idx_d;
  logic [dtp_pkg::ValW-1:0]      vals_q [3];
  logic [dtp_pkg::ValW-1:0]      vals_d [3];
  dtp_pkg::parse_phase_e         phase_q, phase_d;
  logic                          neg_q, neg_d;
  logic [dtp_pkg::CountW-1:0]    count_q, count_d;

  logic                          cmd_fire, res_push;
  dtp_pkg::result_t              res_new;
  logic [dtp_pkg::ValW-1:0]      cur_val, new_val;
  logic signed [ProdW-1:0]       cur_ext, prod;
  logic signed [SumW-1:0]        sum;
  logic                          add_en;

  dtp_pkg::result_t              out0_q, out0_d, out1_q, out1_d;
  logic                          ov0_q, ov0_d, ov1_q, ov1_d;
  logic                          out_pop;

  assign cmd_ready_o = ~ov1_q;
  assign cmd_fire    = cmd_valid_i & ~ov1_q;

  // Times ten plus or minus one digit, saturating at the signed 32-bit bounds.
  always_comb begin
    unique case (idx_q)
      2'd0:    cur_val = vals_q[0];
      2'd1:    cur_val = vals_q[1];
      2'd2:    cur_val = vals_q[2];
      default: cur_val = '0;
    endcase
    cur_ext = ProdW'(signed'(cur_val));
    prod    = (cur_ext <<< 3) + (cur_ext <<< 1);
    if (neg_q) begin
      sum = SumW'(prod) - SumW'(signed'({1'b0, cmd_i.digit}));
      new_val = (sum < SatMin) ? dtp_pkg::ValW'(SatMin) : sum[dtp_pkg::ValW-1:0];
    end else begin
      sum = SumW'(prod) + SumW'(signed'({1'b0, cmd_i.digit}));
      new_val = (sum > SatMax) ? dtp_pkg::ValW'(SatMax) : sum[dtp_pkg::ValW-1:0];
    end
  end

  always_comb begin
    res_new.value_one   = vals_q[0];
    res_new.value_two   = vals_q[1];
    res_new.value_three = vals_q[2];
    res_new.fields_seen = (idx_q >= dtp_pkg::LastField) ? 2'd3 : idx_q + 2'd1;
  end

  // Parser state update for one transaction.
  always_comb begin
    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    vals_d     = vals_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    count_d    = count_q;
    res_push   = 1'b0;
    add_en     = 1'b0;
    if (cmd_fire) begin
      priority if (cmd_i.cls == dtp_pkg::CLS_HASH) begin
        in_frame_d = 1'b1;
        idx_d      = '0;
        vals_d     = '{default: '0};
        phase_d    = dtp_pkg::PH_SKIP;
        neg_d      = 1'b0;
        count_d    = '0;
      end else if (in_frame_q) begin
        unique case (cmd_i.cls)
          dtp_pkg::CLS_BANG: begin
            res_push   = 1'b1;
            in_frame_d = 1'b0;
            idx_d      = '0;
            vals_d     = '{default: '0};
            phase_d    = dtp_pkg::PH_SKIP;
            neg_d      = 1'b0;
            count_d    = '0;
          end
          dtp_pkg::CLS_COMMA: begin
            if (idx_q != dtp_pkg::PastLast) begin
              idx_d = idx_q + 2'd1;
            end
            phase_d = dtp_pkg::PH_SKIP;
            neg_d   = 1'b0;
            count_d = '0;
          end
          default: begin
            if (idx_q != dtp_pkg::PastLast && count_q < MaxCount) begin
              count_d = count_q + 1'b1;
              unique case (phase_q)
                dtp_pkg::PH_SKIP: begin
                  unique case (cmd_i.cls)
                    dtp_pkg::CLS_BLANK: phase_d = dtp_pkg::PH_SKIP;
                    dtp_pkg::CLS_PLUS, dtp_pkg::CLS_MINUS: begin
                      neg_d   = (cmd_i.cls == dtp_pkg::CLS_MINUS);
                      phase_d = dtp_pkg::PH_DIGITS;
                    end
                    dtp_pkg::CLS_DIGIT: begin
                      phase_d = dtp_pkg::PH_DIGITS;
                      add_en  = 1'b1;
                    end
                    default: phase_d = dtp_pkg::PH_DONE;
                  endcase
                end
                dtp_pkg::PH_DIGITS: begin
                  if (cmd_i.cls == dtp_pkg::CLS_DIGIT) begin
                    add_en = 1'b1;
                  end else begin
                    phase_d = dtp_pkg::PH_DONE;
                  end
                end
                default: phase_d = phase_q;
              endcase
            end
          end
        endcase
      end else begin
        in_frame_d = in_frame_q;
      end
    end
    if (add_en) begin
      vals_d[idx_q] = new_val;
    end
  end

  // Two-entry result queue: out0 is on the ports, out1 holds one more.
  assign out_pop     = res_pop_i & ov0_q;
  assign res_valid_o = ov0_q;
  assign res_o       = out0_q;

  always_comb begin
    ov0_d  = ov0_q;
    ov1_d  = ov1_q;
    out0_d = out0_q;
    out1_d = out1_q;
    if (out_pop) begin
      if (ov1_q) begin
        out0_d = out1_q;
        ov1_d  = 1'b0;
      end else if (res_push) begin
        out0_d = res_new;
      end else begin
        ov0_d = 1'b0;
      end
    end else if (res_push) begin
      if (!ov0_q) begin
        out0_d = res_new;
        ov0_d  = 1'b1;
      end else begin
        out1_d = res_new;
        ov1_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      vals_q     <= '{default: '0};
      phase_q    <= dtp_pkg::PH_SKIP;
      neg_q      <= 1'b0;
      count_q    <= '0;
      ov0_q      <= 1'b0;
      ov1_q      <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
      vals_q     <= vals_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      count_q    <= count_d;
      ov0_q      <= ov0_d;
      ov1_q      <= ov1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out0_q <= out0_d;
    out1_q <= out1_d;
  end

endmodule

`default_nettype wire

@@ sv/framed_decimal_triple_parser_top.sv @@
// Framed decimal triple parser: classifier front end, queue, parser back end.
//
// Input channel: a queue interface. Drive rx_byte_i and push_i; the byte is
// taken at a rising edge where push_i is high and full_o is low. One byte
// per cycle is taken in steady state while full_o stays low.
// Result channel: a queue interface. While empty_o is low the oldest frame
// result sits on value_one_o, value_two_o, value_three_o and fields_seen_o;
// it is taken at a rising edge where pop_i is high and empty_o is low.
// Frames: '#' opens or restarts a frame, ',' moves to the next of three
// fields, '!' closes it and yields one result. Fields read like atoi and
// saturate at the signed 32-bit range.
// Result path: a '!' is registered in the front queue; when nothing waits
// ahead of it there, the back end registers its result into the result queue.
// Throughput: one byte per cycle, set by the combinational multiply-by-ten
// and saturate step in the back end; a two-entry queue on each side keeps
// that rate while the receiver pops every cycle.
// Receiver stall: results collect in a two-entry result queue; once it is
// full the back end holds, the front queue fills and full_o goes high.
// Reset: rst_ni low clears both queues and all parser state (no open frame).
`default_nettype none
`include "assert_macros.svh"

module framed_decimal_triple_parser_top #(
  parameter int unsigned MAX_FIELD_CHARS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    full_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic signed [31:0]      value_one_o,
  output logic signed [31:0]      value_two_o,
  output logic signed [31:0]      value_three_o,
  output logic [1:0]              fields_seen_o
);

  logic              cmd_valid, cmd_ready, res_valid;
  dtp_pkg::cmd_t     cmd;
  dtp_pkg::result_t  res;

  dtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  dtp_back #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop_i)
  );

  assign empty_o       = ~res_valid;
  assign value_one_o   = res.value_one;
  assign value_two_o   = res.value_two;
  assign value_three_o = res.value_three;
  assign fields_seen_o = res.fields_seen;

  `DTP_ASSERT_NOW(a_seen_nonzero, !empty_o, fields_seen_o != 2'd0)
  `DTP_ASSERT_NOW(a_full_has_head, full_o, cmd_valid)
  `DTP_ASSERT_NEXT(a_cmd_held, cmd_valid && !cmd_ready, cmd_valid)

endmodule

`default_nettype wire

@@ tb/sv/tb_framed_decimal_triple_parser_top.sv @@
// Testbench for the framed decimal triple parser: random frames against a frame predictor.
`timescale 1ns / 1ps

class frame_scoreboard;
  localparam int unsigned MaxFieldChars = 10;

  // Parser state mirrored from the block.
  bit                      in_frame;
  logic [1:0]              field_idx;
  logic signed [31:0]      field_val [3];
  dtp_pkg::parse_phase_e   phase;
  bit                      neg;
  int unsigned             char_cnt;

  dtp_pkg::result_t        frames_q [$];
  int unsigned             n_frames;
  int unsigned             n_errors;

  function new();
    in_frame = 0;
    clear_frame();
    n_frames = 0;
    n_errors = 0;
  endfunction

  function void clear_field();
    phase    = dtp_pkg::PH_SKIP;
    neg      = 0;
    char_cnt = 0;
  endfunction

  function void clear_frame();
    field_idx = 2'd0;
    for (int i = 0; i < 3; i++) field_val[i] = '0;
    clear_field();
  endfunction

  function void add_digit(int unsigned d);
    longint acc;
    acc = longint'(field_val[field_idx]) * 10;
    if (neg) begin
      acc = acc - longint'(d);
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    end else begin
      acc = acc + longint'(d);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    end
    field_val[field_idx] = acc[31:0];
  endfunction

  function void field_char(logic [7:0] c);
    bit is_digit;
    bit is_blank;
    is_digit = (c >= dtp_pkg::CharZero) && (c <= dtp_pkg::CharNine);
    is_blank = (c == dtp_pkg::CharSpace) || ((c >= dtp_pkg::CharTab) && (c <= dtp_pkg::CharCr));
    if (field_idx > dtp_pkg::LastField) return;
    // Look at only the first MaxFieldChars bytes of a field.
    if (char_cnt >= MaxFieldChars) return;
    char_cnt++;
    case (phase)
      dtp_pkg::PH_SKIP: begin
        if (is_blank) return;
        if (c == dtp_pkg::CharPlus || c == dtp_pkg::CharMinus) begin
          neg   = (c == dtp_pkg::CharMinus);
          phase = dtp_pkg::PH_DIGITS;
        end else if (is_digit) begin
          phase = dtp_pkg::PH_DIGITS;
          add_digit(int'(c - dtp_pkg::CharZero));
        end else begin
          phase = dtp_pkg::PH_DONE;
        end
      end
      dtp_pkg::PH_DIGITS: begin
        if (is_digit) add_digit(int'(c - dtp_pkg::CharZero));
        else phase = dtp_pkg::PH_DONE;
      end
      default: ;
    endcase
  endfunction

  // Advance the predictor by one accepted byte.
  function void note_byte(logic [7:0] c);
    dtp_pkg::result_t res;
    if (c == dtp_pkg::CharHash) begin
      in_frame = 1;
      clear_frame();
    end else if (in_frame) begin
      if (c == dtp_pkg::CharBang) begin
        res.value_one   = field_val[0];
        res.value_two   = field_val[1];
        res.value_three = field_val[2];
        res.fields_seen = (field_idx >= dtp_pkg::LastField) ? 2'd3 : field_idx + 2'd1;
        frames_q.push_back(res);
        n_frames++;
        in_frame = 0;
        clear_frame();
      end else if (c == dtp_pkg::CharComma) begin
        if (field_idx < dtp_pkg::PastLast) field_idx = field_idx + 2'd1;
        clear_field();
      end else begin
        field_char(c);
      end
    end
  endfunction

  function void check_frame(logic signed [31:0] v1, logic signed [31:0] v2,
                            logic signed [31:0] v3, logic [1:0] seen);
    dtp_pkg::result_t exp_res;
    if (frames_q.size() == 0) begin
      $display("%0t: unexpected frame result %0d %0d %0d seen %0d", $time, v1, v2, v3, seen);
      n_errors++;
      return;
    end
    exp_res = frames_q.pop_front();
    if (exp_res.value_one !== v1) begin
      $display("%0t: value_one expected %0d actual %0d", $time, exp_res.value_one, v1);
      n_errors++;
    end
    if (exp_res.value_two !== v2) begin
      $display("%0t: value_two expected %0d actual %0d", $time, exp_res.value_two, v2);
      n_errors++;
    end
    if (exp_res.value_three !== v3) begin
      $display("%0t: value_three expected %0d actual %0d", $time, exp_res.value_three, v3);
      n_errors++;
    end
    if (exp_res.fields_seen !== seen) begin
      $display("%0t: fields_seen expected %0d actual %0d", $time, exp_res.fields_seen, seen);
      n_errors++;
    end
  endfunction
endclass

module tb_framed_decimal_triple_parser_top;

  localparam int unsigned MaxFieldChars = 10;
  localparam int unsigned ByteTarget    = 700;
  localparam int unsigned FrameTarget   = 25;
  localparam int unsigned CycleLimit    = 300000;

  logic               clk_i;
  logic               rst_ni;
  logic               push_i;
  logic [7:0]         rx_byte_i;
  logic               full_o;
  logic               empty_o;
  logic               pop_i;
  logic signed [31:0] value_one_o;
  logic signed [31:0] value_two_o;
  logic signed [31:0] value_three_o;
  logic [1:0]         fields_seen_o;

  frame_scoreboard    sb;
  int unsigned        cycle_cnt;
  int unsigned        burst_left;
  int unsigned        stall_left;
  int unsigned        bytes_sent;

  framed_decimal_triple_parser_top #(
    .MAX_FIELD_CHARS(MaxFieldChars)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .rx_byte_i    (rx_byte_i),
    .full_o       (full_o),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .value_one_o  (value_one_o),
    .value_two_o  (value_two_o),
    .value_three_o(value_three_o),
    .fields_seen_o(fields_seen_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("framed_decimal_triple_parser_top verification failed");
      $finish;
    end
  end

  // Result side: check every popped transaction, stall on a pattern of its own.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i      <= 1'b0;
      stall_left <= 0;
    end else begin
      if (pop_i && !empty_o)
        sb.check_frame(value_one_o, value_two_o, value_three_o, fields_seen_o);
      if (cycle_cnt[9]) begin
        pop_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop_i      <= 1'b0;
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3:  begin stall_left <= $urandom_range(0, 3);  pop_i <= 1'b0; end
          4:           begin stall_left <= $urandom_range(5, 25); pop_i <= 1'b0; end
          default:     pop_i <= 1'b1;
        endcase
      end
    end
  end

  // Send one byte; open a gap first when the current burst is used up.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < gap; i++) begin
        push_i    <= 1'b0;
        rx_byte_i <= 8'($urandom);
        @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
    end
    burst_left--;
    push_i    <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full_o);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // One frame with random fields; now and then break it or drop in noise.
  task automatic send_frame();
    logic [7:0]  frame_q [$];
    int unsigned n_fields;
    int unsigned n_digits;
    logic [7:0]  ch;
    n_fields = $urandom_range(1, 4);
    frame_q.push_back(dtp_pkg::CharHash);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) frame_q.push_back(dtp_pkg::CharComma);
      repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0) begin
        ch = $urandom_range(0, 1) ? dtp_pkg::CharSpace
                                  : dtp_pkg::CharTab + 8'($urandom_range(0, 4));
        frame_q.push_back(ch);
      end
      case ($urandom_range(0, 5))
        0:       frame_q.push_back(dtp_pkg::CharPlus);
        1, 2:    frame_q.push_back(dtp_pkg::CharMinus);
        default: ;
      endcase
      n_digits = ($urandom_range(0, 2) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 6);
      repeat (n_digits) begin
        ch = ($urandom_range(0, 3) == 0) ? dtp_pkg::CharNine
                                         : dtp_pkg::CharZero + 8'($urandom_range(0, 9));
        frame_q.push_back(ch);
      end
      if ($urandom_range(0, 4) == 0) frame_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      if ($urandom_range(0, 9) == 0) frame_q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) != 0) frame_q.push_back(dtp_pkg::CharBang);
    foreach (frame_q[i]) push_byte(frame_q[i]);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
  endtask

  initial begin
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    push_i     = 1'b0;
    rx_byte_i  = 8'h00;
    burst_left = 0;
    bytes_sent = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes outside a frame, saturation, blanks, sign only, extra fields, restart.
    push_byte(8'h00);
    push_byte(dtp_pkg::CharBang);
    push_text("#2147483648,\t-7x5,+,9!");
    push_text("#5#");
    push_byte(8'hFF);
    push_text(",!");

    while (bytes_sent < ByteTarget || sb.n_frames < FrameTarget) send_frame();
    push_text("#1!");
    push_i <= 1'b0;

    while (sb.frames_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.n_errors == 0)
      $display("framed_decimal_triple_parser_top verification clean");
    else
      $display("framed_decimal_triple_parser_top verification failed");
    $finish;
  end
endmodule
